/* hdl/form_field_url_decoder_defines.svh */
`ifndef FORM_FIELD_URL_DECODER_DEFINES_SVH
`define FORM_FIELD_URL_DECODER_DEFINES_SVH

// Check a same-cycle implication at every rising edge outside reset
`define FFUD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition leads to a consequence in the next cycle
`define FFUD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ffud_pkg.sv */
package ffud_pkg;

    // Character codes
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // Configuration register indexes
    localparam logic [1:0] REG_NAME_LOW  = 2'd0;
    localparam logic [1:0] REG_NAME_HIGH = 2'd1;
    localparam logic [1:0] REG_NAME_LEN  = 2'd2;
    localparam logic [1:0] REG_OUT_CAP   = 2'd3;

    localparam logic [4:0] NAME_LEN_RESET = 5'd4;
    localparam logic [7:0] OUT_CAP_RESET  = 8'd63;

    // Decoupling queue between parser and result sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_MATCH,
        PH_SKIP,
        PH_VALUE,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [63:0] name_low;
        logic [63:0] name_high;
        logic [4:0]  name_len;
        logic [7:0]  out_cap;
    } cfg_t;

    // Up to two value bytes and the end-of-body word caused by one input byte
    typedef struct packed {
        logic       b0_vld;
        logic [7:0] b0;
        logic       b1_vld;
        logic [7:0] b1;
        logic       fin;
        logic       found;
    } pkt_t;

    typedef struct packed {
        logic b0;
        logic b1;
        logic fin;
    } res_flags_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF)
            || (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] d;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = c - CH_ZERO;
        else if (c >= CH_LA && c <= CH_LF)
            d = c - CH_LA + 8'd10;
        else
            d = c - CH_UA + 8'd10;
        return d[3:0];
    endfunction

    function automatic logic [7:0] plain(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SP : c;
    endfunction

    // Two-character base-16 conversion: leading white space, optional sign, hex digits
    function automatic logic [7:0] pct_conv(input logic [7:0] c0, input logic [7:0] c1);
        logic [7:0] v;
        logic       neg;
        v   = 8'd0;
        neg = 1'b0;
        if (is_ws(c0))
        begin
            if (is_hex(c1))
                v = {4'h0, hex_nib(c1)};
        end
        else if (c0 == CH_PLUS || c0 == CH_MINUS)
        begin
            neg = (c0 == CH_MINUS);
            if (is_hex(c1))
                v = {4'h0, hex_nib(c1)};
        end
        else if (is_hex(c0))
        begin
            if (is_hex(c1))
                v = {hex_nib(c0), hex_nib(c1)};
            else
                v = {4'h0, hex_nib(c0)};
        end
        if (neg)
            v = ~v + 8'd1;
        return v;
    endfunction

endpackage

/* hdl/ffud_if.sv */
interface ffud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       body_last;

    modport source (output valid, output body_byte, output body_last, input ready);
    modport sink (input valid, input body_byte, input body_last, output ready);
endinterface

interface ffud_out_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] decoded_byte;
    logic       field_found;
    logic       final_res;

    modport source (output valid, output has_byte, output decoded_byte,
                    output field_found, output final_res, input ready);
    modport sink (input valid, input has_byte, input decoded_byte,
                  input field_found, input final_res, output ready);
endinterface

interface ffud_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/ffud_front.sv */
module ffud_front #(
    parameter int NAME_MAX_CHARS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ffud_pkg::cfg_t  cfg,
    ffud_in_if.sink         body_in,
    input  logic            q_full,
    output logic            q_push,
    output ffud_pkg::pkt_t  q_pkt
);
    import ffud_pkg::*;

    localparam logic [4:0] NAME_MAX_W = 5'(NAME_MAX_CHARS);

    phase_t      phase_reg, phase_next, phase_mid;
    logic [4:0]  pos_reg, pos_next, pos_mid;
    logic [1:0]  pend_reg, pend_next, pend_mid;
    logic [7:0]  pf_reg, pf_next, pf_mid;
    logic [7:0]  emitted_reg, emitted_next;
    logic        found_reg, found_next, found_mid;

    logic [7:0]   b;
    logic         last;
    logic         accept;
    logic [4:0]   name_len;
    logic [127:0] name_vec;
    logic [7:0]   name_ch;
    logic [7:0]   conv;
    logic         se_vld, s0_vld, s1_vld, e0, e1;
    logic [7:0]   se_b, s0_b, s1_b;
    logic [1:0]   fl_cnt;
    logic [7:0]   fl_first;
    logic [8:0]   cnt1;

    assign b        = body_in.body_byte;
    assign last     = body_in.body_last;
    assign body_in.ready = !q_full;
    assign accept   = body_in.valid && body_in.ready;
    assign name_len = (cfg.name_len > NAME_MAX_W) ? NAME_MAX_W : cfg.name_len;
    assign name_vec = {cfg.name_high, cfg.name_low};
    assign name_ch  = name_vec[{pos_reg[3:0], 3'b000} +: 8];
    assign conv     = pct_conv(pf_reg, b);

    // Step the parser on the current word
    always_comb
    begin
        phase_mid = phase_reg;
        pos_mid   = pos_reg;
        pend_mid  = pend_reg;
        pf_mid    = pf_reg;
        found_mid = found_reg;
        if (b == 8'd0)
        begin
            if (phase_reg == PH_VALUE)
            begin
                pend_mid = 2'd0;
                pf_mid   = 8'd0;
            end
            phase_mid = PH_DONE;
        end
        else
        begin
            unique case (phase_reg)
                PH_MATCH:
                begin
                    if ((pos_reg < name_len) ? (b == name_ch) : (b == CH_EQ))
                    begin
                        if (pos_reg >= name_len)
                        begin
                            phase_mid = PH_VALUE;
                            found_mid = 1'b1;
                        end
                        else
                            pos_mid = pos_reg + 5'd1;
                    end
                    else
                    begin
                        pos_mid   = 5'd0;
                        phase_mid = (b == CH_AMP) ? PH_MATCH : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (b == CH_AMP)
                    begin
                        phase_mid = PH_MATCH;
                        pos_mid   = 5'd0;
                    end
                end
                PH_VALUE:
                begin
                    if (b == CH_AMP)
                    begin
                        pend_mid  = 2'd0;
                        pf_mid    = 8'd0;
                        phase_mid = PH_DONE;
                    end
                    else if (pend_reg == 2'd0)
                    begin
                        if (b == CH_PCT)
                            pend_mid = 2'd1;
                    end
                    else if (pend_reg == 2'd1)
                    begin
                        pf_mid   = b;
                        pend_mid = 2'd2;
                    end
                    else
                    begin
                        pend_mid = 2'd0;
                        pf_mid   = 8'd0;
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Clear body state after the last word
    always_comb
    begin
        if (last)
        begin
            phase_next   = PH_MATCH;
            pos_next     = 5'd0;
            pend_next    = 2'd0;
            pf_next      = 8'd0;
            found_next   = 1'b0;
            emitted_next = 8'd0;
        end
        else
        begin
            phase_next   = phase_mid;
            pos_next     = pos_mid;
            pend_next    = pend_mid;
            pf_next      = pf_mid;
            found_next   = found_mid;
            emitted_next = emitted_reg + 8'(e0) + 8'(e1);
        end
    end

    // Build the result packet for the current word
    always_comb
    begin
        se_vld = 1'b0;
        se_b   = 8'd0;
        if (b != 8'd0 && phase_reg == PH_VALUE && b != CH_AMP)
        begin
            if (pend_reg == 2'd0 && b != CH_PCT)
            begin
                se_vld = 1'b1;
                se_b   = plain(b);
            end
            else if (pend_reg == 2'd2 && conv != 8'd0)
            begin
                se_vld = 1'b1;
                se_b   = conv;
            end
        end

        // Pending percent escape flushed at value end
        if (phase_reg == PH_VALUE && (b == 8'd0 || b == CH_AMP))
        begin
            fl_cnt   = pend_reg;
            fl_first = pf_reg;
        end
        else if (last && phase_mid == PH_VALUE)
        begin
            fl_cnt   = pend_mid;
            fl_first = pf_mid;
        end
        else
        begin
            fl_cnt   = 2'd0;
            fl_first = 8'd0;
        end

        if (se_vld)
        begin
            s0_vld = 1'b1;
            s0_b   = se_b;
            s1_vld = 1'b0;
            s1_b   = 8'd0;
        end
        else
        begin
            s0_vld = (fl_cnt != 2'd0);
            s0_b   = CH_PCT;
            s1_vld = (fl_cnt == 2'd2);
            s1_b   = plain(fl_first);
        end

        // Drop bytes beyond the output capacity
        e0   = s0_vld && (emitted_reg < cfg.out_cap);
        cnt1 = {1'b0, emitted_reg} + 9'(e0);
        e1   = s1_vld && (cnt1 < {1'b0, cfg.out_cap});

        q_pkt.b0_vld = e0;
        q_pkt.b0     = s0_b;
        q_pkt.b1_vld = e1;
        q_pkt.b1     = s1_b;
        q_pkt.fin    = last;
        q_pkt.found  = found_mid;
        q_push       = accept && (e0 || e1 || last);
    end

    // Advance parser state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MATCH;
            pos_reg     <= 5'd0;
            pend_reg    <= 2'd0;
            pf_reg      <= 8'd0;
            emitted_reg <= 8'd0;
            found_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            pend_reg    <= pend_next;
            pf_reg      <= pf_next;
            emitted_reg <= emitted_next;
            found_reg   <= found_next;
        end
    end

endmodule

/* hdl/ffud_queue.sv */
module ffud_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ffud_pkg::pkt_t  push_pkt,
    output logic            full,
    input  logic            pop,
    output ffud_pkg::pkt_t  pop_pkt,
    output logic            empty
);
    import ffud_pkg::*;

    pkt_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_pkt = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    // Store pushed packets
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_pkt;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* hdl/ffud_back.sv */
module ffud_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ffud_pkg::pkt_t  pkt_in,
    input  logic            q_empty,
    output logic            q_pop,
    ffud_out_if.source      dec_out
);
    import ffud_pkg::*;

    res_flags_t rem_reg, rem_next, rem_after;
    logic [7:0] b0_reg, b1_reg;
    logic       found_reg;
    logic       accept;
    logic       byte_sel;

    // Present the first pending word of the held packet
    always_comb
    begin
        byte_sel             = rem_reg.b0 || rem_reg.b1;
        dec_out.valid        = byte_sel || rem_reg.fin;
        dec_out.has_byte     = byte_sel;
        dec_out.decoded_byte = rem_reg.b0 ? b0_reg : (rem_reg.b1 ? b1_reg : 8'd0);
        dec_out.field_found  = !byte_sel && found_reg;
        dec_out.final_res    = !byte_sel && rem_reg.fin;
    end

    assign accept = dec_out.valid && dec_out.ready;

    // Drop the delivered word and load the next packet when drained
    always_comb
    begin
        rem_after = rem_reg;
        if (accept)
        begin
            priority if (rem_reg.b0)
                rem_after.b0 = 1'b0;
            else if (rem_reg.b1)
                rem_after.b1 = 1'b0;
            else
                rem_after.fin = 1'b0;
        end
        q_pop = !q_empty && (rem_after == '0);
        if (q_pop)
        begin
            rem_next.b0  = pkt_in.b0_vld;
            rem_next.b1  = pkt_in.b1_vld;
            rem_next.fin = pkt_in.fin;
        end
        else
            rem_next = rem_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

    // Hold packet payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b0_reg    <= pkt_in.b0;
            b1_reg    <= pkt_in.b1;
            found_reg <= pkt_in.found;
        end
    end

endmodule

/* hdl/form_field_url_decoder.sv */
// Form field extractor with URL decoding.
// body_in takes one word per cycle while its ready is high: a body byte and body_last on the final byte.
// At body start and after each '&' the bytes are compared with the configured
// field name and '='; the first matching field's value is decoded ('+' to space,
// '%xx' to a byte, zero results dropped) and sent on dec_out one byte per word.
// Each body ends with one word carrying final_res and field_found.
// cfg writes the name, its length and the output byte limit; it is always ready
// and must only be written while the block is idle.
// Throughput: one body byte per cycle while dec_out is ready and no more than one
// result per byte is produced; a byte that ends a value with a pending escape yields
// up to three words, delivered one per cycle by the result sequencer while dec_out is ready.
// A result reaches dec_out through the packet queue, which the parser writes when
// its byte is accepted, and then the sequencer's output register, which loads it
// from the queue once the previously held packet has been delivered.
// A four-entry packet queue separates parser and sequencer; body_in.ready drops
// only when that queue is full, so a stalled receiver backs up after five packets
// (one held by the sequencer, four queued).
// Reset clears parser state, queue and output; configuration returns to name
// length 4, output limit 63 and an all-zero name.
`include "form_field_url_decoder_defines.svh"

module form_field_url_decoder #(
    parameter int NAME_MAX_CHARS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    ffud_in_if.sink     body_in,
    ffud_out_if.source  dec_out,
    ffud_cfg_if.sink    cfg
);
    import ffud_pkg::*;

    cfg_t cfg_reg;
    pkt_t push_pkt, pop_pkt;
    logic q_push, q_pop, q_full, q_empty;

    assign cfg.ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.name_low  <= 64'd0;
            cfg_reg.name_high <= 64'd0;
            cfg_reg.name_len  <= NAME_LEN_RESET;
            cfg_reg.out_cap   <= OUT_CAP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_NAME_LOW:  cfg_reg.name_low  <= cfg.data;
                REG_NAME_HIGH: cfg_reg.name_high <= cfg.data;
                REG_NAME_LEN:  cfg_reg.name_len  <= cfg.data[4:0];
                REG_OUT_CAP:   cfg_reg.out_cap   <= cfg.data[7:0];
                default:       cfg_reg.out_cap   <= cfg_reg.out_cap;
            endcase
        end
    end

    ffud_front #(
        .NAME_MAX_CHARS (NAME_MAX_CHARS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .body_in (body_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_pkt   (push_pkt)
    );

    ffud_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_pkt (push_pkt),
        .full     (q_full),
        .pop      (q_pop),
        .pop_pkt  (pop_pkt),
        .empty    (q_empty)
    );

    ffud_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt_in  (pop_pkt),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .dec_out (dec_out)
    );

    `FFUD_ASSERT_NOW(a_push_not_full, q_push, !q_full, "packet pushed into full queue")
    `FFUD_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty, "packet popped from empty queue")
    `FFUD_ASSERT_NEXT(a_pop_shows_word, q_pop, dec_out.valid, "loaded packet shows no word")
    `FFUD_ASSERT_NOW(a_final_no_byte, dec_out.valid && dec_out.final_res, !dec_out.has_byte && dec_out.decoded_byte == 8'd0, "final word carries a byte")

endmodule

/* tb/form_field_url_decoder_tb.sv */
`timescale 1ns / 100ps

module form_field_url_decoder_tb;
    import ffud_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int NAME_CHARS     = 16;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] decoded_byte;
        logic       field_found;
        logic       final_res;
    } dec_word_t;

    logic clk;
    logic rst_n;

    ffud_in_if  body_in ();
    ffud_out_if dec_out ();
    ffud_cfg_if cfg ();

    form_field_url_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .body_in (body_in),
        .dec_out (dec_out),
        .cfg     (cfg)
    );

    // Decoder copy: configuration and per-body state
    logic [127:0] cfg_name;
    logic [4:0]   cfg_name_len;
    logic [7:0]   cfg_out_cap;
    phase_t       pr_phase;
    logic [4:0]   pr_pos;
    logic [1:0]   pr_pend_cnt;
    logic [7:0]   pr_pend_first;
    logic [7:0]   pr_emitted;
    logic         pr_found;

    dec_word_t  expected_words[$];
    dec_word_t  head_word;
    logic [7:0] body_buf[$];

    int errors;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int bytes_sent;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic is_space_char(input logic [7:0] c);
        return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Valid flag in bit 4, digit value below
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, c[3:0]};
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            return {1'b1, c[3:0] + 4'd9};
        return 5'd0;
    endfunction

    // Two-character base-16 read: skip white space, optional sign, digits
    function automatic logic [7:0] escape_value(input logic [7:0] c0, input logic [7:0] c1);
        logic [1:0][7:0] chars;
        int              i;
        logic [7:0]      val;
        logic            neg;
        logic [4:0]      d;
        chars[0] = c0;
        chars[1] = c1;
        i   = 0;
        val = 8'd0;
        neg = 1'b0;
        while (i < 2 && is_space_char(chars[i]))
            i++;
        if (i < 2 && (chars[i] == CH_PLUS || chars[i] == CH_MINUS))
        begin
            neg = (chars[i] == CH_MINUS);
            i++;
        end
        while (i < 2)
        begin
            d = hex_digit(chars[i]);
            if (!d[4])
                break;
            val = {val[3:0], d[3:0]};
            i++;
        end
        if (neg)
            val = 8'd0 - val;
        return val;
    endfunction

    function automatic logic [7:0] name_char(input int k);
        return cfg_name[8 * (k % NAME_CHARS) +: 8];
    endfunction

    function automatic logic [4:0] name_len_eff();
        return (cfg_name_len > NAME_CHARS) ? 5'(NAME_CHARS) : cfg_name_len;
    endfunction

    function automatic logic [7:0] to_plain(input logic [7:0] b);
        return (b == CH_PLUS) ? CH_SP : b;
    endfunction

    // Queue one value byte unless the output limit is reached
    function automatic void push_byte(input logic [7:0] b);
        dec_word_t w;
        if (pr_emitted < cfg_out_cap)
        begin
            w.has_byte     = 1'b1;
            w.decoded_byte = b;
            w.field_found  = 1'b0;
            w.final_res    = 1'b0;
            expected_words.push_back(w);
            pr_emitted++;
        end
    endfunction

    // Copy an unfinished escape literally
    function automatic void flush_escape();
        if (pr_pend_cnt >= 2'd1)
            push_byte(CH_PCT);
        if (pr_pend_cnt >= 2'd2)
            push_byte(to_plain(pr_pend_first));
        pr_pend_cnt   = 2'd0;
        pr_pend_first = 8'd0;
    endfunction

    function automatic void clear_body();
        pr_phase      = PH_MATCH;
        pr_pos        = 5'd0;
        pr_pend_cnt   = 2'd0;
        pr_pend_first = 8'd0;
        pr_emitted    = 8'd0;
        pr_found      = 1'b0;
    endfunction

    // Advance the decoder copy by one body byte and queue the words it causes
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        logic [4:0] len;
        logic       hit;
        logic [7:0] v;
        dec_word_t  w;
        len = name_len_eff();
        if (b == 8'd0)
        begin
            if (pr_phase == PH_VALUE)
                flush_escape();
            pr_phase = PH_DONE;
        end
        else
        begin
            case (pr_phase)
                PH_MATCH:
                begin
                    if (pr_pos < len)
                        hit = (b == name_char(int'(pr_pos)));
                    else
                        hit = (b == CH_EQ);
                    if (hit)
                    begin
                        if (pr_pos >= len)
                        begin
                            pr_phase = PH_VALUE;
                            pr_found = 1'b1;
                        end
                        else
                            pr_pos++;
                    end
                    else
                    begin
                        pr_pos   = 5'd0;
                        pr_phase = (b == CH_AMP) ? PH_MATCH : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (b == CH_AMP)
                    begin
                        pr_phase = PH_MATCH;
                        pr_pos   = 5'd0;
                    end
                end
                PH_VALUE:
                begin
                    if (b == CH_AMP)
                    begin
                        flush_escape();
                        pr_phase = PH_DONE;
                    end
                    else if (pr_pend_cnt == 2'd0)
                    begin
                        if (b == CH_PCT)
                            pr_pend_cnt = 2'd1;
                        else
                            push_byte(to_plain(b));
                    end
                    else if (pr_pend_cnt == 2'd1)
                    begin
                        pr_pend_first = b;
                        pr_pend_cnt   = 2'd2;
                    end
                    else
                    begin
                        v = escape_value(pr_pend_first, b);
                        if (v != 8'd0)
                            push_byte(v);
                        pr_pend_cnt   = 2'd0;
                        pr_pend_first = 8'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (last)
        begin
            if (pr_phase == PH_VALUE)
                flush_escape();
            w.has_byte     = 1'b0;
            w.decoded_byte = 8'd0;
            w.field_found  = pr_found;
            w.final_res    = 1'b1;
            expected_words.push_back(w);
            clear_body();
        end
    endfunction

    // Send one body byte; valid stays high on return
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            body_in.valid <= 1'b0;
            @(posedge clk);
        end
        body_in.valid     <= 1'b1;
        body_in.body_byte <= b;
        body_in.body_last <= last;
        @(posedge clk);
        while (!body_in.ready)
            @(posedge clk);
        predict_byte(b, last);
    endtask

    // Send the buffered body, marking its final byte
    task automatic send_body();
        int i;
        for (i = 0; i < body_buf.size(); i++)
            send_byte(body_buf[i], i == body_buf.size() - 1);
        bytes_sent += body_buf.size();
        body_buf.delete();
    endtask

    task automatic append_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            body_buf.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        append_text(s);
        send_body();
    endtask

    // Hold off the sender until every expected word is in, then let the pipe empty
    task automatic drain();
        body_in.valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            REG_NAME_LOW:  cfg_name[63:0]   = value;
            REG_NAME_HIGH: cfg_name[127:64] = value;
            REG_NAME_LEN:  cfg_name_len     = value[4:0];
            REG_OUT_CAP:   cfg_out_cap      = value[7:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic configure_name(input string nm, input logic [7:0] cap);
        logic [127:0] bits;
        int           k;
        bits = '0;
        for (k = 0; k < nm.len() && k < NAME_CHARS; k++)
            bits[8 * k +: 8] = nm[k];
        drain();
        write_reg(REG_NAME_LOW, bits[63:0]);
        write_reg(REG_NAME_HIGH, bits[127:64]);
        write_reg(REG_NAME_LEN, 64'(nm.len()));
        write_reg(REG_OUT_CAP, {56'd0, cap});
    endtask

    function automatic logic [7:0] rand_name_char();
        logic [7:0] specials[4];
        specials = '{CH_AMP, CH_EQ, CH_PCT, CH_PLUS};
        if ($urandom_range(9) == 0)
            return specials[$urandom_range(3)];
        return 8'("a" + $urandom_range(25));
    endfunction

    // Random name, length and limit; unused register bits carry noise
    task automatic configure_random(input logic [7:0] cap);
        logic [127:0] bits;
        int           len;
        int           k;
        bits = {$urandom, $urandom, $urandom, $urandom};
        len  = ($urandom_range(7) == 0) ? $urandom_range(31, 17) : $urandom_range(16);
        for (k = 0; k < len && k < NAME_CHARS; k++)
            bits[8 * k +: 8] = rand_name_char();
        drain();
        write_reg(REG_NAME_LOW, bits[63:0]);
        write_reg(REG_NAME_HIGH, bits[127:64]);
        write_reg(REG_NAME_LEN, {32'($urandom), 27'($urandom), 5'(len)});
        write_reg(REG_OUT_CAP, {32'($urandom), 24'($urandom), cap});
    endtask

    // Value byte weighted toward escapes, signs and hex digits
    function automatic logic [7:0] rand_value_char();
        int         r;
        logic [7:0] hex_set[22];
        hex_set = '{"0", "1", "2", "3", "4", "5", "6", "7", "8", "9", "a", "b", "c",
                    "d", "e", "f", "A", "B", "C", "D", "E", "F"};
        r = $urandom_range(99);
        if (r < 18)
            return CH_PCT;
        if (r < 40)
            return hex_set[$urandom_range(21)];
        if (r < 48)
            return CH_PLUS;
        if (r < 54)
            return CH_MINUS;
        if (r < 58)
            return CH_SP;
        if (r < 61)
            return 8'($urandom_range(13, 9));
        if (r < 66)
            return 8'($urandom_range(255, 128));
        if (r < 68)
            return 8'd0;
        if (r < 84)
            return 8'("g" + $urandom_range(19));
        return 8'($urandom_range(255, 1));
    endfunction

    // Field name: mostly the configured one, else a prefix, a near miss or junk
    task automatic append_field_name();
        int eff;
        int r;
        int k;
        int cut;
        eff = int'(name_len_eff());
        r   = $urandom_range(99);
        if (r < 60)
        begin
            for (k = 0; k < eff; k++)
                body_buf.push_back(name_char(k));
        end
        else if (r < 75)
        begin
            cut = $urandom_range(eff);
            for (k = 0; k < cut; k++)
                body_buf.push_back(name_char(k));
        end
        else if (r < 88 && eff > 0)
        begin
            cut = $urandom_range(eff - 1);
            for (k = 0; k < eff; k++)
                body_buf.push_back((k == cut) ? 8'("a" + $urandom_range(25)) : name_char(k));
        end
        else
        begin
            repeat ($urandom_range(4, 1))
                body_buf.push_back(8'("a" + $urandom_range(25)));
        end
    endtask

    // Build a body of name=value fields, sometimes cut short, or pure noise
    task automatic build_random_body();
        int nfields;
        int f;
        int r;
        r = $urandom_range(99);
        if (r < 15)
        begin
            repeat ($urandom_range(8, 1))
                body_buf.push_back(8'($urandom_range(255)));
        end
        else
        begin
            nfields = $urandom_range(3, 1);
            if ($urandom_range(9) == 0)
                body_buf.push_back(CH_AMP);
            for (f = 0; f < nfields; f++)
            begin
                if (f > 0)
                    body_buf.push_back(CH_AMP);
                append_field_name();
                if ($urandom_range(9) != 0)
                    body_buf.push_back(CH_EQ);
                repeat ($urandom_range(6))
                    body_buf.push_back(rand_value_char());
            end
            if (r >= 88)
            begin
                repeat ($urandom_range(3, 1))
                    if (body_buf.size() > 1)
                        void'(body_buf.pop_back());
            end
        end
        if (body_buf.size() == 0)
            body_buf.push_back(rand_value_char());
    endtask

    task automatic run_random_bodies(input int byte_goal);
        int start;
        logic paused;
        start  = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < byte_goal)
        begin
            build_random_body();
            send_body();
            // Pause once mid-stream until the decoder has caught up
            if (!paused && bytes_sent - start >= byte_goal / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    // Reset values: an all-zero name can never match
    task automatic test_reset_config();
        send_text("ab=c&=d");
    endtask

    task automatic test_plain_values();
        configure_name("key", 8'd63);
        send_text("key=a+b&c=d");
        send_text("kez&key=1&key=2");
        send_text("key=");
    endtask

    task automatic test_percent_escapes();
        send_text("key=%41%-1% f%+a%00%1g%\t5%--%FF%  ");
    endtask

    task automatic test_short_escape();
        send_text("key=x%4&y");
        send_text("key=%");
        send_text("key=%+");
    endtask

    task automatic test_zero_byte();
        append_text("key=ab");
        body_buf.push_back(8'd0);
        append_text("cd");
        send_body();
        append_text("key=%4");
        body_buf.push_back(8'd0);
        append_text("z");
        send_body();
        body_buf.push_back(8'd0);
        append_text("key=x");
        send_body();
    endtask

    task automatic test_name_lengths();
        configure_name("", 8'd63);
        send_text("=v&=w");
        configure_name("abcdefghijklmnop", 8'd255);
        // Lengths above the name size saturate
        drain();
        write_reg(REG_NAME_LEN, {59'd0, 5'd31});
        send_text("x&abcdefghijklmnop=s");
        // Name holding the field separator
        configure_name("a&b", 8'd63);
        send_text("a&a&b=1&a&b=2");
    endtask

    task automatic test_capacity();
        configure_name("key", 8'd0);
        send_text("key=ab");
        configure_name("key", 8'd2);
        send_text("key=a%4");
        configure_name("key", 8'd255);
        send_text("key=%41");
    endtask

    task automatic test_extreme_bytes();
        drain();
        write_reg(REG_NAME_LOW, '1);
        write_reg(REG_NAME_HIGH, '1);
        write_reg(REG_NAME_LEN, 64'd3);
        body_buf = '{8'hFF, 8'hFF, 8'hFF, CH_EQ, 8'h80, 8'hFF, 8'h01, 8'h7F};
        send_body();
    endtask

    task automatic test_random_traffic();
        int round;
        logic [7:0] cap;
        for (round = 0; round < 4; round++)
        begin
            case (round)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 59;
                end
                default:
                begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
            endcase
            case (round % 4)
                0:       cap = 8'd255;
                1:       cap = 8'd0;
                2:       cap = 8'($urandom_range(4, 1));
                default: cap = 8'($urandom_range(255));
            endcase
            configure_random(cap);
            run_random_bodies(8);
        end
    endtask

    // Check each accepted word against the oldest expectation; randomize ready
    always @(posedge clk)
    begin
        if (!rst_n)
            dec_out.ready <= 1'b0;
        else
        begin
            if (dec_out.valid && dec_out.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("decoded word with none expected: has_byte %0d byte %02h final %0d",
                           dec_out.has_byte, dec_out.decoded_byte, dec_out.final_res);
                    errors++;
                end
                else
                begin
                    head_word = expected_words.pop_front();
                    if (dec_out.has_byte !== head_word.has_byte)
                    begin
                        $error("has_byte: expected %0d, actual %0d",
                               head_word.has_byte, dec_out.has_byte);
                        errors++;
                    end
                    if (dec_out.decoded_byte !== head_word.decoded_byte)
                    begin
                        $error("decoded_byte: expected %02h, actual %02h",
                               head_word.decoded_byte, dec_out.decoded_byte);
                        errors++;
                    end
                    if (dec_out.field_found !== head_word.field_found)
                    begin
                        $error("field_found: expected %0d, actual %0d",
                               head_word.field_found, dec_out.field_found);
                        errors++;
                    end
                    if (dec_out.final_res !== head_word.final_res)
                    begin
                        $error("final_res: expected %0d, actual %0d",
                               head_word.final_res, dec_out.final_res);
                        errors++;
                    end
                end
            end
            dec_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run when no channel moves a word for too long
    always @(posedge clk)
    begin
        if ((body_in.valid && body_in.ready) || (dec_out.valid && dec_out.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("form_field_url_decoder_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        body_in.valid     <= 1'b0;
        body_in.body_byte <= 8'd0;
        body_in.body_last <= 1'b0;
        cfg.valid         <= 1'b0;
        cfg.index         <= REG_NAME_LOW;
        cfg.data          <= 64'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bytes_sent     = 0;
        cfg_name       = '0;
        cfg_name_len   = NAME_LEN_RESET;
        cfg_out_cap    = OUT_CAP_RESET;
        clear_body();

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_plain_values();
        test_percent_escapes();
        test_short_escape();
        test_zero_byte();
        test_name_lengths();
        test_capacity();
        test_extreme_bytes();
        test_random_traffic();

        drain();
        if (errors == 0)
            $display("form_field_url_decoder_tb OK");
        else
            $display("form_field_url_decoder_tb NOT OK");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/ffud_pkg.sv
hdl/ffud_if.sv
hdl/ffud_front.sv
hdl/ffud_queue.sv
hdl/ffud_back.sv
hdl/form_field_url_decoder.sv
tb/form_field_url_decoder_tb.sv
